### rtl/sgo_pkg.sv
package sgo_pkg;

  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned OFFSET_W = 50;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned NUM_DIMS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM0_SIZE   = 4'd0,
    REG_DIM1_SIZE   = 4'd1,
    REG_DIM2_SIZE   = 4'd2,
    REG_DIM3_SIZE   = 4'd3,
    REG_DIM0_STRIDE = 4'd4,
    REG_DIM1_STRIDE = 4'd5,
    REG_DIM2_STRIDE = 4'd6,
    REG_DIM3_STRIDE = 4'd7
  } reg_idx_t;

  // travels with every word down the chain
  typedef struct packed {
    logic vld;
    logic zero;
  } sgo_ctl_t;

endpackage

### rtl/sgo_div_cell.sv
module sgo_div_cell #(
  parameter int unsigned IW = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [sgo_pkg::SIZE_W-1:0]    divisor,
  input  sgo_pkg::sgo_ctl_t             ctl_i,
  input  logic [IW-1:0]                 num_i,
  input  logic [sgo_pkg::SIZE_W-1:0]    rem_i,
  input  logic [sgo_pkg::OFFSET_W-1:0]  acc_i,
  output sgo_pkg::sgo_ctl_t             ctl_o,
  output logic [IW-1:0]                 num_o,
  output logic [sgo_pkg::SIZE_W-1:0]    rem_o,
  output logic [sgo_pkg::OFFSET_W-1:0]  acc_o
);

  sgo_pkg::sgo_ctl_t            ctl_r;
  logic [IW-1:0]                num_r, num_nxt;
  logic [sgo_pkg::SIZE_W-1:0]   rem_r, rem_nxt;
  logic [sgo_pkg::OFFSET_W-1:0] acc_r;
  logic [sgo_pkg::SIZE_W:0]     trial;
  logic                         ge;

  // one restoring step: quotient bit shifts in where the dividend bit left
  always_comb begin
    trial   = {rem_i, num_i[IW-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? sgo_pkg::SIZE_W'(trial - {1'b0, divisor}) : trial[sgo_pkg::SIZE_W-1:0];
    num_nxt = {num_i[IW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      acc_r <= acc_i;
    end
  end

  assign ctl_o = ctl_r;
  assign num_o = num_r;
  assign rem_o = rem_r;
  assign acc_o = acc_r;

endmodule

### rtl/sgo_dim.sv
module sgo_dim #(
  parameter int unsigned IW = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [sgo_pkg::SIZE_W-1:0]    size,
  input  logic [sgo_pkg::SIZE_W-1:0]    stride,
  input  sgo_pkg::sgo_ctl_t             ctl_i,
  input  logic [IW-1:0]                 num_i,
  input  logic [sgo_pkg::OFFSET_W-1:0]  acc_i,
  output sgo_pkg::sgo_ctl_t             ctl_o,
  output logic [IW-1:0]                 num_o,
  output logic [sgo_pkg::OFFSET_W-1:0]  acc_o
);

  sgo_pkg::sgo_ctl_t            c_ctl [0:IW];
  logic [IW-1:0]                c_num [0:IW];
  logic [sgo_pkg::SIZE_W-1:0]   c_rem [0:IW];
  logic [sgo_pkg::OFFSET_W-1:0] c_acc [0:IW];

  sgo_pkg::sgo_ctl_t            ctl_r;
  logic [IW-1:0]                num_r;
  logic [sgo_pkg::OFFSET_W-1:0] acc_r, acc_nxt;
  logic [sgo_pkg::SIZE_W-1:0]   coord;
  logic [2*sgo_pkg::SIZE_W-1:0] prod;

  // a zero size kills this dimension and every outer one
  always_comb begin
    c_ctl[0]      = ctl_i;
    c_ctl[0].zero = ctl_i.zero | (size == '0);
    c_num[0]      = num_i;
    c_rem[0]      = '0;
    c_acc[0]      = acc_i;
  end

  for (genvar i = 0; i < IW; i++) begin : g_cell
    sgo_div_cell #(.IW(IW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .divisor(size),
      .ctl_i  (c_ctl[i]),
      .num_i  (c_num[i]),
      .rem_i  (c_rem[i]),
      .acc_i  (c_acc[i]),
      .ctl_o  (c_ctl[i+1]),
      .num_o  (c_num[i+1]),
      .rem_o  (c_rem[i+1]),
      .acc_o  (c_acc[i+1])
    );
  end

  always_comb begin
    coord   = c_ctl[IW].zero ? '0 : c_rem[IW];
    prod    = coord * stride;
    acc_nxt = c_acc[IW] + sgo_pkg::OFFSET_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= c_ctl[IW];
    end
    if (en) begin
      num_r <= c_num[IW];
      acc_r <= acc_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign num_o = num_r;
  assign acc_o = acc_r;

endmodule

### rtl/strided_gather_offset.sv
// Strided gather address generator. Each linear_index word is split into
// mixed-radix coordinates, innermost dimension first, by a chain of one-bit
// restoring division cells (INDEX_WIDTH cells plus one multiply-accumulate
// stage per inner dimension); the outermost active dimension takes the final
// quotient unreduced. One word is accepted per cycle while the output is taken.
// Sizes and strides are read live from the register file and must only be
// written while the chain is empty.
module strided_gather_offset #(
  parameter int unsigned DIMS        = 4,
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [31:0]                       in_linear_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sgo_pkg::OFFSET_W-1:0]      out_source_offset,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgo_pkg::SIZE_W-1:0]        cfg_data
);

  localparam int unsigned FIRST = sgo_pkg::NUM_DIMS - DIMS;

  logic [sgo_pkg::SIZE_W-1:0] size_r   [0:sgo_pkg::NUM_DIMS-1];
  logic [sgo_pkg::SIZE_W-1:0] stride_r [0:sgo_pkg::NUM_DIMS-1];

  sgo_pkg::sgo_ctl_t            s_ctl [0:DIMS-1];
  logic [INDEX_WIDTH-1:0]       s_num [0:DIMS-1];
  logic [sgo_pkg::OFFSET_W-1:0] s_acc [0:DIMS-1];

  logic                         en;
  logic                         out_valid_r;
  logic [sgo_pkg::OFFSET_W-1:0] out_offset_r, out_offset_nxt;
  logic [INDEX_WIDTH-1:0]       outer_coord;
  logic                         outer_zero;
  logic [INDEX_WIDTH+sgo_pkg::SIZE_W-1:0] outer_prod;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < sgo_pkg::NUM_DIMS; d++) begin
        size_r[d]   <= sgo_pkg::SIZE_W'(1);
        stride_r[d] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        sgo_pkg::REG_DIM0_SIZE:   size_r[0]   <= cfg_data;
        sgo_pkg::REG_DIM1_SIZE:   size_r[1]   <= cfg_data;
        sgo_pkg::REG_DIM2_SIZE:   size_r[2]   <= cfg_data;
        sgo_pkg::REG_DIM3_SIZE:   size_r[3]   <= cfg_data;
        sgo_pkg::REG_DIM0_STRIDE: stride_r[0] <= cfg_data;
        sgo_pkg::REG_DIM1_STRIDE: stride_r[1] <= cfg_data;
        sgo_pkg::REG_DIM2_STRIDE: stride_r[2] <= cfg_data;
        sgo_pkg::REG_DIM3_STRIDE: stride_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    s_ctl[0].vld  = in_valid;
    s_ctl[0].zero = 1'b0;
    s_num[0]      = INDEX_WIDTH'(in_linear_index);
    s_acc[0]      = '0;
  end

  // stage k peels off dimension 3-k
  for (genvar k = 0; k < DIMS - 1; k++) begin : g_dim
    sgo_dim #(.IW(INDEX_WIDTH)) u_dim (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .size  (size_r[sgo_pkg::NUM_DIMS-1-k]),
      .stride(stride_r[sgo_pkg::NUM_DIMS-1-k]),
      .ctl_i (s_ctl[k]),
      .num_i (s_num[k]),
      .acc_i (s_acc[k]),
      .ctl_o (s_ctl[k+1]),
      .num_o (s_num[k+1]),
      .acc_o (s_acc[k+1])
    );
  end

  // outermost active dimension: quotient used as is
  always_comb begin
    outer_zero     = s_ctl[DIMS-1].zero || (size_r[FIRST] == '0);
    outer_coord    = outer_zero ? '0 : s_num[DIMS-1];
    outer_prod     = outer_coord * stride_r[FIRST];
    out_offset_nxt = s_acc[DIMS-1] + sgo_pkg::OFFSET_W'(outer_prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_ctl[DIMS-1].vld;
    end
    if (en) begin
      out_offset_r <= out_offset_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_source_offset = out_offset_r;

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY = 3 * 33 + 1;
  localparam int unsigned SETTLE = LATENCY + 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [sgo_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 4'd9;

  typedef logic [sgo_pkg::OFFSET_W-1:0] offset_t;

  typedef struct {
    logic [31:0] index;
    bit          typed;
    offset_t     offset;
  } stim_row_t;

  typedef struct {
    bit      typed;
    offset_t offset;
  } typed_word_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [31:0]                   in_linear_index;
  logic                          out_valid;
  logic                          out_ready;
  offset_t                       out_source_offset;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [sgo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sgo_pkg::SIZE_W-1:0]    cfg_data;

  logic [sgo_pkg::SIZE_W-1:0] dim_size [sgo_pkg::NUM_DIMS];
  logic [sgo_pkg::SIZE_W-1:0] dim_stride [sgo_pkg::NUM_DIMS];

  offset_t     offset_q [$];
  typed_word_t typed_q [$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          hold_req;
  bit          no_gaps;

  strided_gather_offset u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_linear_index  (in_linear_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_source_offset(out_source_offset),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mixed-radix split of the index, dimension 0 outermost and unreduced
  function automatic offset_t gather_offset(logic [31:0] index);
    logic [63:0] inner;
    logic [63:0] coord;
    logic [63:0] sum;
    sum = '0;
    inner = 64'd1;
    for (int d = sgo_pkg::NUM_DIMS - 1; d >= 0; d--) begin
      if (dim_stride[d] != 0) begin
        coord = (inner != 0) ? ({32'd0, index} / inner) : 64'd0;
        if (dim_size[d] == 0) coord = '0;
        else if (d != 0) coord = coord % dim_size[d];
        sum += coord * dim_stride[d];
      end
      inner = inner * dim_size[d];
    end
    return sum[sgo_pkg::OFFSET_W-1:0];
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // scoreboard: predict on input accept, compare on output accept
  always @(posedge clk) begin
    typed_word_t tw;
    offset_t     want;
    if (rst_n && in_valid && in_ready) begin
      tw = typed_q.pop_front();
      offset_q.push_back(tw.typed ? tw.offset : gather_offset(in_linear_index));
    end
    if (rst_n && out_valid && out_ready) begin
      if (offset_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: offset %h", out_source_offset);
      end else begin
        want = offset_q.pop_front();
        if (out_source_offset !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("offset mismatch: expected %h actual %h", want, out_source_offset);
        end
      end
    end
  end

  initial begin
    int unsigned r;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int unsigned n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 0;
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end else begin
          out_ready <= no_gaps || r < 75;
        end
      end
    end
  end

  task automatic write_reg(logic [sgo_pkg::CFG_IDX_W-1:0] idx,
                           logic [sgo_pkg::SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx < sgo_pkg::NUM_DIMS) dim_size[idx[1:0]] = data;
    else if (idx < 2 * sgo_pkg::NUM_DIMS) dim_stride[idx[1:0]] = data;
    @(posedge clk);
  endtask

  task automatic load_geometry(logic [sgo_pkg::SIZE_W-1:0] s0, s1, s2, s3, t0, t1, t2, t3);
    write_reg(sgo_pkg::REG_DIM0_SIZE, s0);
    write_reg(sgo_pkg::REG_DIM1_SIZE, s1);
    write_reg(sgo_pkg::REG_DIM2_SIZE, s2);
    write_reg(sgo_pkg::REG_DIM3_SIZE, s3);
    write_reg(sgo_pkg::REG_DIM0_STRIDE, t0);
    write_reg(sgo_pkg::REG_DIM1_STRIDE, t1);
    write_reg(sgo_pkg::REG_DIM2_STRIDE, t2);
    write_reg(sgo_pkg::REG_DIM3_STRIDE, t3);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (offset_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_word(logic [31:0] index, bit typed, offset_t offset);
    int unsigned r;
    int unsigned gap;
    typed_q.push_back('{typed, offset});
    in_valid        <= 1'b1;
    in_linear_index <= index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = $urandom_range(0, 99);
    gap = no_gaps || r < 50 ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [sgo_pkg::SIZE_W-1:0] rand_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 12) return 16'hFFFF;
    if (r < 20) return sgo_pkg::SIZE_W'($urandom());
    return sgo_pkg::SIZE_W'($urandom_range(1, 12));
  endfunction

  function automatic logic [sgo_pkg::SIZE_W-1:0] rand_stride();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 30) return 16'hFFFF;
    if (r < 60) return sgo_pkg::SIZE_W'($urandom());
    return sgo_pkg::SIZE_W'($urandom_range(1, 64));
  endfunction

  stim_row_t reset_rows [4] = '{
    '{32'h0000_0000, 1'b1, '0},
    '{32'hFFFF_FFFF, 1'b1, '0},
    '{32'h8000_0000, 1'b1, '0},
    '{32'h0000_0001, 1'b1, '0}
  };

  // all sizes one, only the outermost stride set: offset equals the index
  stim_row_t flat_rows [4] = '{
    '{32'h0000_0000, 1'b1, 50'h0},
    '{32'hFFFF_FFFF, 1'b1, 50'hFFFF_FFFF},
    '{32'hA5A5_5A5A, 1'b1, 50'hA5A5_5A5A},
    '{32'h0000_0001, 1'b1, 50'h1}
  };

  stim_row_t extreme_rows [6] = '{
    '{32'h0000_0000, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'h0000_FFFE, 1'b0, '0},
    '{32'h0000_FFFF, 1'b0, '0},
    '{32'h5555_AAAA, 1'b0, '0},
    '{32'hAAAA_5555, 1'b0, '0}
  };

  stim_row_t odd_rows [6] = '{
    '{32'd0, 1'b0, '0},
    '{32'd6, 1'b0, '0},
    '{32'd7, 1'b0, '0},
    '{32'd20, 1'b0, '0},
    '{32'd1000, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, '0}
  };

  initial begin
    int unsigned elems;
    logic [31:0] index;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_linear_index = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    hold_req = 0;
    no_gaps = 0;
    for (int d = 0; d < sgo_pkg::NUM_DIMS; d++) begin
      dim_size[d] = 1;
      dim_stride[d] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (reset_rows[i]) send_word(reset_rows[i].index, reset_rows[i].typed, reset_rows[i].offset);
    wait_idle();
    load_geometry(1, 1, 1, 1, 1, 0, 0, 0);
    foreach (flat_rows[i]) send_word(flat_rows[i].index, flat_rows[i].typed, flat_rows[i].offset);
    wait_idle();
    load_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    foreach (extreme_rows[i]) send_word(extreme_rows[i].index, 1'b0, '0);
    wait_idle();
    // zero sizes, a broadcast axis, and an index past the tensor end
    load_geometry(0, 3, 0, 7, 16'h1234, 0, 16'hFFFF, 9);
    write_reg(REG_UNMAPPED, 16'hBEEF);
    foreach (odd_rows[i]) send_word(odd_rows[i].index, 1'b0, '0);
    wait_idle();
    load_geometry(2, 3, 4, 5, 60, 20, 5, 1);
    foreach (odd_rows[i]) send_word(odd_rows[i].index, 1'b0, '0);

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      if (ph == 2) write_reg(REG_UNMAPPED, 16'h0001);
      load_geometry(rand_size(), rand_size(), rand_size(), rand_size(),
                    rand_stride(), rand_stride(), rand_stride(), rand_stride());
      no_gaps = (ph == 3);
      elems = dim_size[0] * dim_size[1] * dim_size[2] * dim_size[3];
      // the gapless phase is long enough to fill the chain during the hold
      for (int n = 0; n < (ph == 3 ? 130 : 53); n++) begin
        if (ph == 3 && n == 0) hold_req = 1;
        if (ph == 4 && n == 30) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (offset_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 99) < 35 || elems == 0) index = $urandom();
        else index = $urandom_range(0, elems - 1);
        send_word(index, 1'b0, '0);
      end
    end
    no_gaps = 0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (offset_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/sgo_pkg.sv
rtl/sgo_div_cell.sv
rtl/sgo_dim.sv
rtl/strided_gather_offset.sv
tb/testbench.sv
